### src/sxd_pkg.sv
package sxd_pkg;

  localparam int SPRITE_W = 8;
  localparam int COORD_W  = 9;   // origin plus offset, up to 270
  localparam int CNT_W    = 4;   // iteration count of the remainder unit
  localparam int BASE_W   = 15;  // row * stride, at most 127 * 255
  localparam int IDX_W    = 16;  // linear pixel index before the range check
  localparam int PADDR_W  = 4;

  localparam logic KIND_DRAW = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CLIP   = 2'd2;

  localparam logic [7:0] WIDTH_RST  = 8'd64;
  localparam logic [6:0] HEIGHT_RST = 7'd32;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_MOD   = 8'b0000_0100,
    S_MUL   = 8'b0000_1000,
    S_PIX   = 8'b0001_0000,
    S_WR    = 8'b0010_0000,
    S_RDW   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

endpackage

### src/sxd_ram.sv
module sxd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/sxd_rem.sv
// Restoring remainder, one dividend bit per cycle.
module sxd_rem
  import sxd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [COORD_W-1:0] dividend,
  input  logic [7:0]         divisor,
  output logic               done,
  output logic [7:0]         remainder
);

  logic [COORD_W-1:0] dvd_r;
  logic [7:0]         rem_r;
  logic [7:0]         div_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [8:0]         trial;
  logic [8:0]         diff;
  logic               ge;

  assign trial = {rem_r, dvd_r[COORD_W-1]};
  assign ge    = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(COORD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[7:0] : trial[7:0];
      dvd_r <= {dvd_r[COORD_W-2:0], 1'b0};
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

### src/sprite_xor_draw_engine.sv
// One-bit framebuffer with XOR sprite drawing and a running collision flag. After reset
// the framebuffer is cleared one pixel per cycle, with in_ready low. A draw request is
// accepted, waits for the coordinate remainder units, does the row multiply, then per
// sprite bit either skips the pixel or does a framebuffer read-modify-write, and then
// posts the result. A read request reads the framebuffer and posts the result. The
// single-port-pair RAM with its registered read sets the per-pixel cost. A new
// request is accepted while the previous result still waits on out_ready.
module sprite_xor_draw_engine
  import sxd_pkg::*;
#(
  parameter int MAX_PIXELS = 8192
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic [7:0]         in_origin_x,
  input  logic [7:0]         in_origin_y,
  input  logic [3:0]         in_row_offset,
  input  logic [7:0]         in_sprite_row,
  input  logic               in_first_row,
  input  logic               in_last_row,
  input  logic [12:0]        in_read_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_collision,
  output logic               out_sprite_done,
  output logic               out_pixel_value,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int AW = $clog2(MAX_PIXELS);

  state_t state_r, state_nxt;

  logic [7:0]          width_r;
  logic [6:0]          height_r;
  logic                clip_r;

  logic                kind_r;
  logic [SPRITE_W-1:0] bits_r;
  logic                last_r;
  logic                rd_ok_r;
  logic                pix_r;
  logic                hit_r;
  logic                skip_r;
  logic [COORD_W-1:0]  x_r;
  logic [COORD_W-1:0]  y_r;
  logic [BASE_W-1:0]   base_r;
  logic [2:0]          b_r;
  logic [AW-1:0]       addr_r;
  logic [AW-1:0]       clr_r;

  logic                out_valid_r;
  logic                out_coll_r;
  logic                out_done_r;
  logic                out_pix_r;

  logic                accept;
  logic                cfg_wr;
  logic [COORD_W-1:0]  y_sum;
  logic                rem_start;
  logic                xrem_done, yrem_done;
  logic [7:0]          xrem, yrem;
  logic [COORD_W-1:0]  x_sel, y_sel;
  logic [IDX_W-1:0]    pix_idx;
  logic [31:0]         pix_idx32;
  logic [31:0]         ridx32;
  logic                bit_set;
  logic                pix_on;
  logic                last_bit;
  logic [COORD_W-1:0]  x_inc, x_step;
  logic                out_free;

  logic                ram_we, ram_re, ram_rdata;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic                ram_wdata;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      clip_r   <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_WIDTH:  width_r  <= cfg_pwdata[7:0];
        REG_HEIGHT: height_r <= cfg_pwdata[6:0];
        REG_CLIP:   clip_r   <= cfg_pwdata[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_WIDTH:  cfg_prdata = {24'd0, width_r};
      REG_HEIGHT: cfg_prdata = {25'd0, height_r};
      REG_CLIP:   cfg_prdata = {31'd0, clip_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // coordinate remainders for wrap mode
  assign accept    = in_valid & in_ready;
  assign y_sum     = {1'b0, in_origin_y} + COORD_W'(in_row_offset);
  assign rem_start = accept & (in_kind == KIND_DRAW);

  sxd_rem u_xrem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rem_start),
    .dividend  ({1'b0, in_origin_x}),
    .divisor   (width_r),
    .done      (xrem_done),
    .remainder (xrem)
  );

  sxd_rem u_yrem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rem_start),
    .dividend  (y_sum),
    .divisor   ({1'b0, height_r}),
    .done      (yrem_done),
    .remainder (yrem)
  );

  // clip mode: x_r/y_r keep the raw coordinates; wrap mode: they follow the remainders
  assign x_sel = clip_r ? x_r : {1'b0, xrem};
  assign y_sel = clip_r ? y_r : {1'b0, yrem};

  // pixel walk
  assign pix_idx   = {1'b0, base_r} + IDX_W'(x_r);
  assign pix_idx32 = {16'd0, pix_idx};
  assign ridx32    = {19'd0, in_read_index};
  assign bit_set   = bits_r[3'(SPRITE_W - 1) - b_r];
  assign pix_on    = bit_set & ~skip_r & (~clip_r | (x_r < {1'b0, width_r}))
                   & (pix_idx32 < 32'(MAX_PIXELS));
  assign last_bit  = b_r == 3'(SPRITE_W - 1);
  assign x_inc     = x_r + 1'b1;
  assign x_step    = (~clip_r && x_inc == {1'b0, width_r}) ? '0 : x_inc;
  assign out_free  = ~out_valid_r | out_ready;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == AW'(MAX_PIXELS - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) state_nxt = (in_kind == KIND_DRAW) ? S_MOD : S_RDW;
      end
      S_MOD:   if (xrem_done && yrem_done) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_PIX;
      S_PIX: begin
        if (pix_on) state_nxt = S_WR;
        else if (last_bit) state_nxt = S_DONE;
      end
      S_WR:    state_nxt = last_bit ? S_DONE : S_PIX;
      S_RDW:   state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (accept && in_kind == KIND_DRAW && in_first_row) hit_r <= 1'b0;
      if (state_r == S_WR && ram_rdata) hit_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        kind_r  <= in_kind;
        bits_r  <= in_sprite_row;
        last_r  <= in_last_row;
        rd_ok_r <= ridx32 < 32'(MAX_PIXELS);
        pix_r   <= 1'b0;
        x_r     <= {1'b0, in_origin_x};
        y_r     <= y_sum;
      end
      S_MOD: begin
        x_r    <= x_sel;
        y_r    <= y_sel;
        skip_r <= (width_r == '0) | (height_r == '0)
                | (clip_r & (y_r >= {2'b00, height_r}));
      end
      S_MUL: begin
        // y_r is below the height here unless the row is skipped
        base_r <= BASE_W'(y_r[6:0]) * BASE_W'(width_r);
        b_r    <= '0;
      end
      S_PIX: begin
        addr_r <= pix_idx32[AW-1:0];
        if (!pix_on && !last_bit) begin
          b_r <= b_r + 1'b1;
          x_r <= x_step;
        end
      end
      S_WR: begin
        if (!last_bit) begin
          b_r <= b_r + 1'b1;
          x_r <= x_step;
        end
      end
      S_RDW:   pix_r <= rd_ok_r & ram_rdata;
      default: ;
    endcase
  end

  // framebuffer
  assign ram_re    = (state_r == S_IDLE) | (state_r == S_PIX);
  assign ram_raddr = (state_r == S_IDLE) ? ridx32[AW-1:0] : pix_idx32[AW-1:0];
  assign ram_we    = (state_r == S_CLEAR) | (state_r == S_WR);
  assign ram_waddr = (state_r == S_CLEAR) ? clr_r : addr_r;
  assign ram_wdata = (state_r == S_CLEAR) ? 1'b0 : ~ram_rdata;

  sxd_ram #(
    .WIDTH (1),
    .DEPTH (MAX_PIXELS)
  ) u_fb (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_coll_r <= hit_r;
      out_done_r <= (kind_r == KIND_DRAW) & last_r;
      out_pix_r  <= pix_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_collision   = out_coll_r;
  assign out_sprite_done = out_done_r;
  assign out_pixel_value = out_pix_r;

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result posted without finishing a request");

  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |-> ($past(state_r == S_PIX) && $past(pix_on)))
    else $error("framebuffer write without a preceding read");

  a_read_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r != S_CLEAR) |-> (kind_r == KIND_DRAW))
    else $error("framebuffer written during a read request");

  a_draw_pix_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_done_r && out_pix_r))
    else $error("draw result carries a pixel value");

endmodule

### tb/sv/tb_sprite_xor_draw_engine.sv
`timescale 1ns / 100ps

module tb_sprite_xor_draw_engine
  import sxd_pkg::*;
();

  localparam int FRAME_PIXELS   = 8192;
  localparam int WATCHDOG_LIMIT = 50000;
  localparam int SETTLE_CYCLES  = 40;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    bit       kind;
    bit [7:0] origin_x;
    bit [7:0] origin_y;
    bit [3:0] row_offset;
    bit [7:0] sprite_row;
    bit       first_row;
    bit       last_row;
    bit [12:0] read_index;
  } draw_req_t;

  typedef struct {
    bit collision;
    bit sprite_done;
    bit pixel_value;
  } vf_result_t;

  class vf_frame_scoreboard;
    bit frame_bits [FRAME_PIXELS];
    bit hit;
    int unsigned width_reg;
    int unsigned height_reg;
    bit clip_reg;
    vf_result_t expected_q [$];
    int errors;

    function new();
      foreach (frame_bits[i]) frame_bits[i] = 1'b0;
      hit        = 1'b0;
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      clip_reg   = 1'b1;
      errors     = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_WIDTH:  width_reg = value[7:0];
        REG_HEIGHT: height_reg = value[6:0];
        REG_CLIP:   clip_reg = value[0];
        default: ;
      endcase
    endfunction

    function void flip_pixel(int unsigned tx, int unsigned ty);
      int unsigned idx;
      if (width_reg == 0 || height_reg == 0) return;
      if (clip_reg) begin
        if (tx >= width_reg || ty >= height_reg) return;
      end else begin
        tx = tx % width_reg;
        ty = ty % height_reg;
      end
      idx = tx + ty * width_reg;
      if (idx >= FRAME_PIXELS) return;
      if (frame_bits[idx]) hit = 1'b1;
      frame_bits[idx] = ~frame_bits[idx];
    endfunction

    function void note_request(draw_req_t r);
      vf_result_t res;
      res.sprite_done = 1'b0;
      res.pixel_value = 1'b0;
      if (r.kind == KIND_DRAW) begin
        if (r.first_row) hit = 1'b0;
        for (int b = 0; b < SPRITE_W; b++) begin
          if (r.sprite_row[SPRITE_W-1-b])
            flip_pixel(r.origin_x + b, r.origin_y + r.row_offset);
        end
        res.sprite_done = r.last_row;
      end else begin
        res.pixel_value = frame_bits[r.read_index];
      end
      res.collision = hit;
      expected_q.push_back(res);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(bit collision, bit sprite_done, bit pixel_value);
      vf_result_t exp_res;
      if (expected_q.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        exp_res = expected_q.pop_front();
        if (collision != exp_res.collision)
          report($sformatf("collision got %0b exp %0b", collision, exp_res.collision));
        if (sprite_done != exp_res.sprite_done)
          report($sformatf("sprite_done got %0b exp %0b", sprite_done, exp_res.sprite_done));
        if (pixel_value != exp_res.pixel_value)
          report($sformatf("pixel_value got %0b exp %0b", pixel_value, exp_res.pixel_value));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_kind;
  logic [7:0] in_origin_x;
  logic [7:0] in_origin_y;
  logic [3:0] in_row_offset;
  logic [7:0] in_sprite_row;
  logic in_first_row;
  logic in_last_row;
  logic [12:0] in_read_index;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_collision;
  logic out_sprite_done;
  logic out_pixel_value;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  vf_frame_scoreboard sb;
  draw_req_t mon_req;
  bit mon_moved;
  int stall_cycles = 0;
  int req_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cur_w;
  int cur_h;

  sprite_xor_draw_engine uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_origin_x(in_origin_x), .in_origin_y(in_origin_y),
    .in_row_offset(in_row_offset), .in_sprite_row(in_sprite_row),
    .in_first_row(in_first_row), .in_last_row(in_last_row),
    .in_read_index(in_read_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_collision(out_collision), .out_sprite_done(out_sprite_done),
    .out_pixel_value(out_pixel_value),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      mon_moved = 1'b0;
      if (in_valid && in_ready) begin
        mon_req.kind       = in_kind;
        mon_req.origin_x   = in_origin_x;
        mon_req.origin_y   = in_origin_y;
        mon_req.row_offset = in_row_offset;
        mon_req.sprite_row = in_sprite_row;
        mon_req.first_row  = in_first_row;
        mon_req.last_row   = in_last_row;
        mon_req.read_index = in_read_index;
        sb.note_request(mon_req);
        mon_moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        sb.check_result(out_collision, out_sprite_done, out_pixel_value);
        mon_moved = 1'b1;
      end
      if (mon_moved) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_req(bit kind, bit [7:0] ox, bit [7:0] oy, bit [3:0] row,
                          bit [7:0] bits, bit first, bit last, bit [12:0] ridx);
    if (req_count < 600) begin
      send_idle_pct = 26;
      recv_idle_pct = 78;
    end else if (req_count < 1200) begin
      send_idle_pct = 78;
      recv_idle_pct = 26;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_origin_x   <= ox;
    in_origin_y   <= oy;
    in_row_offset <= row;
    in_sprite_row <= bits;
    in_first_row  <= first;
    in_last_row   <= last;
    in_read_index <= ridx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    req_count++;
    @(negedge clk);
  endtask

  task automatic send_draw(bit [7:0] ox, bit [7:0] oy, bit [3:0] row, bit [7:0] bits,
                           bit first, bit last);
    send_req(KIND_DRAW, ox, oy, row, bits, first, last, 13'($urandom()));
  endtask

  // draw-only fields carry junk on reads
  task automatic send_read(bit [12:0] ridx);
    send_req(KIND_READ, 8'($urandom()), 8'($urandom()), 4'($urandom()), 8'($urandom()),
             1'($urandom()), 1'($urandom()), ridx);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [7:0] value);
    logic [31:0] data;
    data = $urandom();
    case (idx)
      REG_WIDTH:  data[7:0] = value;
      REG_HEIGHT: data[6:0] = value[6:0];
      REG_CLIP:   data[0] = value[0];
      default: ;
    endcase
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_register(idx, data);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_screen(int w, int h, bit clip);
    drain();
    cfg_write(REG_WIDTH, 8'(w));
    cfg_write(REG_HEIGHT, 8'(h));
    cfg_write(REG_CLIP, 8'(clip));
    cur_w = w;
    cur_h = h;
  endtask

  function automatic bit [7:0] pick_coord(int extent);
    if (extent > 0 && $urandom_range(0, 3) != 0)
      return 8'($urandom_range(0, (extent > 256 ? 256 : extent) - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic bit [12:0] pick_read_index();
    int area;
    area = cur_w * cur_h;
    if (area == 0 || area > FRAME_PIXELS || $urandom_range(0, 9) == 0) area = FRAME_PIXELS;
    return 13'($urandom_range(0, area - 1));
  endfunction

  task automatic run_random(int count);
    int sent;
    int sel;
    int nrows;
    bit [7:0] ox;
    bit [7:0] oy;
    bit [7:0] rows [16];
    sent = 0;
    while (sent < count) begin
      sel = $urandom_range(0, 99);
      if (sel == 0) begin
        // hold off until the engine has drained
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
      end
      if (sel < 65) begin
        nrows = $urandom_range(1, 16);
        ox = pick_coord(cur_w);
        oy = pick_coord(cur_h);
        for (int k = 0; k < nrows; k++) begin
          rows[k] = 8'($urandom());
          send_draw(ox, oy, 4'(k), rows[k], k == 0, k == nrows - 1);
        end
        sent += nrows;
        // redraw to erase, which must raise collision where anything was lit
        if ($urandom_range(0, 2) == 0) begin
          for (int k = 0; k < nrows; k++)
            send_draw(ox, oy, 4'(k), rows[k], k == 0, k == nrows - 1);
          sent += nrows;
        end
      end else if (sel < 85) begin
        send_read(pick_read_index());
        sent++;
      end else begin
        send_req(1'($urandom()), 8'($urandom()), 8'($urandom()), 4'($urandom()),
                 8'($urandom()), 1'($urandom()), 1'($urandom()), 13'($urandom()));
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_kind       = KIND_DRAW;
    in_origin_x   = '0;
    in_origin_y   = '0;
    in_row_offset = '0;
    in_sprite_row = '0;
    in_first_row  = 1'b0;
    in_last_row   = 1'b0;
    in_read_index = '0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    cur_w         = WIDTH_RST;
    cur_h         = HEIGHT_RST;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: default 64x32 screen with clipping
    set_screen(64, 32, 1'b1);
    send_read(13'd0);
    send_read(13'd8191);
    send_draw(8'd0, 8'd0, 4'd0, 8'hFF, 1'b1, 1'b1);
    send_draw(8'd0, 8'd0, 4'd0, 8'hFF, 1'b1, 1'b1);
    send_draw(8'd60, 8'd31, 4'd0, 8'hFF, 1'b1, 1'b0);
    send_draw(8'd60, 8'd31, 4'd1, 8'h81, 1'b0, 1'b1);
    send_draw(8'd255, 8'd255, 4'd15, 8'hFF, 1'b1, 1'b1);
    send_draw(8'd0, 8'd0, 4'd0, 8'h00, 1'b1, 1'b1);
    send_draw(8'd56, 8'd0, 4'd0, 8'h80, 1'b0, 1'b0);
    send_draw(8'd56, 8'd0, 4'd0, 8'h80, 1'b0, 1'b0);
    // read ignores the row flags and keeps the flag
    send_req(KIND_READ, 8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1, 1'b1, 13'd56);
    send_draw(8'd3, 8'd5, 4'd0, 8'hA5, 1'b1, 1'b1);
    send_read(13'd323);
    send_read(13'd324);
    send_read(13'd2047);
    // wrap mode around both edges
    set_screen(64, 32, 1'b0);
    send_draw(8'd62, 8'd30, 4'd3, 8'hFF, 1'b1, 1'b1);
    send_read(13'd126);
    send_read(13'd69);
    send_draw(8'd255, 8'd255, 4'd15, 8'hFF, 1'b1, 1'b1);
    send_draw(8'd62, 8'd30, 4'd3, 8'hFF, 1'b1, 1'b1);
    send_read(13'd126);
    drain();
    cfg_write(REG_UNUSED, 8'($urandom()));
    send_read(13'd127);

    run_random(160);
    set_screen(128, 64, 1'b1);
    run_random(160);
    set_screen(128, 64, 1'b0);
    run_random(160);
    set_screen(1, 1, 1'b0);
    run_random(160);
    set_screen(0, 7, 1'b1);
    run_random(160);
    set_screen(9, 0, 1'b0);
    run_random(160);
    // beyond storage: linear index can pass the end of the framebuffer
    set_screen(255, 127, 1'b1);
    run_random(160);
    set_screen(255, 127, 1'b0);
    cfg_write(REG_UNUSED, 8'($urandom()));
    run_random(160);
    set_screen($urandom_range(1, 128), $urandom_range(1, 64), 1'($urandom()));
    run_random(160);
    set_screen($urandom_range(1, 128), $urandom_range(1, 64), 1'($urandom()));
    run_random(160);

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
src/sxd_pkg.sv
src/sxd_ram.sv
src/sxd_rem.sv
src/sprite_xor_draw_engine.sv
tb/sv/tb_sprite_xor_draw_engine.sv
